// ===== rtl/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] DEPTH_24      = 16'd24;
    localparam logic [15:0] DEPTH_32      = 16'd32;
    localparam logic [5:0]  HDR_LAST      = 6'd53;
    localparam logic [31:0] HDR_LEN       = 32'd54;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 1'b1;

    localparam logic [15:0] FB_WIDTH_RST  = 16'd640;
    localparam logic [15:0] FB_HEIGHT_RST = 16'd480;

    localparam int PIX_W = 56;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_IDLE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [23:0] color;
        logic [15:0] y;
        logic [15:0] x;
    } t_pixel;

endpackage

// ===== rtl/bmpd_parser.sv =====
// ----------------------------------------------------------------------------
// bmpd_parser
// Header capture, pixel byte assembly, row padding skip and clipping.
// ----------------------------------------------------------------------------
module bmpd_parser
    import bmpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_fb_width,
    input  logic [15:0] i_fb_height,
    output logic        o_pix_valid,
    output t_pixel      o_pix
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_byte_count, n_byte_count;
    logic [15:0] r_signature, n_signature;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [15:0] r_depth, n_depth;
    logic        r_is32, n_is32;
    logic        r_top_down, n_top_down;
    logic [31:0] r_abs_h, n_abs_h;
    logic [31:0] r_col, n_col;
    logic [31:0] r_row, n_row;
    logic [31:0] r_y, n_y;
    logic [1:0]  r_rb, n_rb;
    logic [1:0]  r_bip, n_bip;
    logic [15:0] r_acc, n_acc;

    t_phase      eff_phase;
    logic [31:0] idx;
    logic [1:0]  pad;
    logic [1:0]  rb_inc;
    logic [31:0] col_inc;
    logic [31:0] row_inc;
    logic        end_row;
    logic        emit;
    logic        in_data;

    always_comb begin
        eff_phase    = i_first_byte ? PH_HEADER : r_phase;
        idx          = i_first_byte ? 32'd0 : r_byte_count;
        n_byte_count = (idx == 32'hFFFF_FFFF) ? idx : idx + 32'd1;
        pad          = r_is32 ? 2'd0 : r_width[1:0];
        rb_inc       = r_rb + 2'd1;
        col_inc      = r_col + 32'd1;
        row_inc      = r_row + 32'd1;
        in_data      = !(idx < HDR_LEN || idx < r_offset);

        n_phase     = eff_phase;
        n_signature = r_signature;
        n_offset    = r_offset;
        n_width     = r_width;
        n_height    = r_height;
        n_depth     = r_depth;
        n_is32      = r_is32;
        n_top_down  = r_top_down;
        n_abs_h     = r_abs_h;
        n_col       = r_col;
        n_row       = r_row;
        n_y         = r_y;
        n_rb        = r_rb;
        n_bip       = r_bip;
        n_acc       = r_acc;
        end_row     = 1'b0;
        emit        = 1'b0;

        case (eff_phase)
            PH_HEADER: begin
                case (idx[5:0])
                    6'd0:  n_signature[7:0]  = i_data_byte;
                    6'd1:  n_signature[15:8] = i_data_byte;
                    6'd10: n_offset[7:0]     = i_data_byte;
                    6'd11: n_offset[15:8]    = i_data_byte;
                    6'd12: n_offset[23:16]   = i_data_byte;
                    6'd13: n_offset[31:24]   = i_data_byte;
                    6'd18: n_width[7:0]      = i_data_byte;
                    6'd19: n_width[15:8]     = i_data_byte;
                    6'd20: n_width[23:16]    = i_data_byte;
                    6'd21: n_width[31:24]    = i_data_byte;
                    6'd22: n_height[7:0]     = i_data_byte;
                    6'd23: n_height[15:8]    = i_data_byte;
                    6'd24: n_height[23:16]   = i_data_byte;
                    6'd25: n_height[31:24]   = i_data_byte;
                    6'd28: n_depth[7:0]      = i_data_byte;
                    6'd29: n_depth[15:8]     = i_data_byte;
                    default: ;
                endcase
                if (idx[5:0] == HDR_LAST) begin
                    if (r_signature == BMP_SIGNATURE
                            && (r_depth == DEPTH_24 || r_depth == DEPTH_32)
                            && r_width != 32'd0 && !r_width[31]
                            && r_height != 32'd0) begin
                        n_phase = PH_PIXELS;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                    n_is32     = (r_depth == DEPTH_32);
                    n_top_down = r_height[31];
                    n_abs_h    = r_height[31] ? (~r_height + 32'd1) : r_height;
                    n_y        = r_height[31] ? 32'd0 : (r_height - 32'd1);
                    n_col      = 32'd0;
                    n_row      = 32'd0;
                    n_rb       = 2'd0;
                    n_bip      = 2'd0;
                end
            end
            PH_PIXELS: begin
                if (in_data) begin
                    if (r_col >= r_width) begin
                        if (rb_inc >= pad) begin
                            end_row = 1'b1;
                        end else begin
                            n_rb = rb_inc;
                        end
                    end else begin
                        case (r_bip)
                            2'd0: n_acc[7:0]  = i_data_byte;
                            2'd1: n_acc[15:8] = i_data_byte;
                            2'd2: emit = (r_col < {16'd0, i_fb_width})
                                         && (r_y < {16'd0, i_fb_height});
                            default: ;
                        endcase
                        if (r_bip == (r_is32 ? 2'd3 : 2'd2)) begin
                            n_bip = 2'd0;
                            if (col_inc >= r_width && pad == 2'd0) begin
                                end_row = 1'b1;
                            end else begin
                                n_col = col_inc;
                            end
                        end else begin
                            n_bip = r_bip + 2'd1;
                        end
                    end
                    if (end_row) begin
                        n_col = 32'd0;
                        n_rb  = 2'd0;
                        n_row = row_inc;
                        n_y   = r_top_down ? r_y + 32'd1 : r_y - 32'd1;
                        if (row_inc >= r_abs_h) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= 32'd0;
            r_col        <= 32'd0;
            r_row        <= 32'd0;
            r_rb         <= 2'd0;
            r_bip        <= 2'd0;
            r_is32       <= 1'b0;
            r_top_down   <= 1'b0;
            r_abs_h      <= 32'd0;
            r_y          <= 32'd0;
            r_width      <= 32'd0;
            r_offset     <= 32'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_col        <= n_col;
            r_row        <= n_row;
            r_rb         <= n_rb;
            r_bip        <= n_bip;
            r_is32       <= n_is32;
            r_top_down   <= n_top_down;
            r_abs_h      <= n_abs_h;
            r_y          <= n_y;
            r_width      <= n_width;
            r_offset     <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_signature <= n_signature;
            r_height    <= n_height;
            r_depth     <= n_depth;
            r_acc       <= n_acc;
        end
    end

    assign o_pix_valid = i_accept && emit;
    assign o_pix.x     = r_col[15:0];
    assign o_pix.y     = r_y[15:0];
    assign o_pix.color = {i_data_byte, r_acc};

    a_bip_24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS && !r_is32) |-> r_bip != 2'd3)
        else $error("pixel byte index out of range at 24 bpp");

    a_pad_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> r_rb != 2'd3)
        else $error("padding count out of range");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> r_col <= r_width)
        else $error("column count beyond image width");

endmodule

// ===== rtl/bmpd_skid.sv =====
// ----------------------------------------------------------------------------
// bmpd_skid
// Output register with a skid stage for the pixel result channel.
// ----------------------------------------------------------------------------
module bmpd_skid
    import bmpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pixel i_pix,
    output logic   o_ready,
    output logic   o_valid,
    output t_pixel o_pix,
    input  logic   i_ready
);

    logic   r_ov;
    logic   r_sv;
    t_pixel r_out;
    t_pixel r_skid;
    logic   out_free;

    assign out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_sv || i_valid;
            r_sv <= 1'b0;
        end else if (i_valid) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_sv ? r_skid : i_pix;
        end
        if (!out_free && i_valid) begin
            r_skid <= i_pix;
        end
    end

    assign o_ready = !r_sv;
    assign o_valid = r_ov;
    assign o_pix   = r_out;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage full while output register empty");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_ready) |=> (r_ov && !r_sv))
        else $error("skid stage did not drain");

endmodule

// ===== rtl/bmp_pixel_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_core
// BMP file byte stream in, clipped framebuffer pixel writes out.
// ----------------------------------------------------------------------------
// Input stream: one file byte per item on tdata, tuser set on the first byte
// of each file. Accepted at one byte per cycle; tready drops only while the
// skid stage holds a pixel behind a stalled output.
// Output stream: one item per pixel inside the framebuffer, carrying column,
// row and RGB color. A pixel enters the output register at the edge that
// accepts its last color byte, or the skid stage if the output stalls.
// Header and padding bytes, clipped pixels and rejected files give no output.
// Configuration: writes to the framebuffer width (index 0) and height
// (index 1); always ready, applied at the write edge.
// Throughput is one byte per cycle while tready is high, one parser step per byte.
// Reset brings the framebuffer to 640 x 480 and the parser to the header
// phase, ready for byte 0 with or without tuser. A stalled receiver holds
// the output item; one more pixel parks in the skid stage, then input waits.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_core
    import bmpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // data_byte
    input  logic                 i_s_axis_tuser,   // first_byte
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [PIX_W-1:0]     o_m_axis_tdata,   // pixel_x, pixel_y, pixel_color
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_fb_width;
    logic [15:0] r_fb_height;
    logic        accept;
    logic        pix_valid;
    t_pixel      pix;
    t_pixel      out_pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= FB_WIDTH_RST;
            r_fb_height <= FB_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    bmpd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_s_axis_tdata),
        .i_first_byte (i_s_axis_tuser),
        .i_fb_width   (r_fb_width),
        .i_fb_height  (r_fb_height),
        .o_pix_valid  (pix_valid),
        .o_pix        (pix)
    );

    bmpd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pix_valid),
        .i_pix   (pix),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_pix   (out_pix),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = out_pix;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the BMP pixel stream decoder core.
// ----------------------------------------------------------------------------
// Builds BMP files byte by byte, sends them through the input stream in
// bursts with random gaps and keeps its own model of the header parser and
// the pixel walk to predict every framebuffer write. A checker compares each
// output item with the oldest predicted pixel while the output side stalls
// on a shifting pattern. Framebuffer size changes only while the block idles.
// ----------------------------------------------------------------------------
module tb_top;
    import bmpd_pkg::*;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [7:0]           i_s_axis_tdata  = '0;
    logic                 i_s_axis_tuser  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [15:0]          i_cfg_data      = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [PIX_W-1:0]     o_m_axis_tdata;
    logic                 o_cfg_ready;

    bmp_pixel_stream_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    t_phase      parse_phase;
    logic [31:0] byte_pos;
    logic [15:0] hdr_sig;
    logic [31:0] hdr_offset;
    logic [31:0] hdr_width;
    logic [31:0] hdr_height;
    logic [15:0] hdr_depth;
    logic [31:0] col_pos;
    logic [31:0] row_pos;
    logic [31:0] pad_seen;
    int unsigned pix_byte;
    logic [23:0] color_acc;
    logic [15:0] fb_w;
    logic [15:0] fb_h;

    t_pixel      pending_pixels[$];
    bit          failed       = 1'b0;
    int unsigned pixels_seen  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned burst_max    = 20;
    int unsigned gap_max      = 3;

    logic [15:0] ready_pat = 16'hFFFF;
    int unsigned pat_age   = 0;

    task automatic restart_parser();
        parse_phase = PH_HEADER;
        byte_pos    = '0;
        hdr_sig     = '0;
        hdr_offset  = '0;
        hdr_width   = '0;
        hdr_height  = '0;
        hdr_depth   = '0;
        col_pos     = '0;
        row_pos     = '0;
        pad_seen    = '0;
        pix_byte    = 0;
        color_acc   = '0;
    endtask

    function automatic logic [31:0] rows_total();
        return hdr_height[31] ? (32'd0 - hdr_height) : hdr_height;
    endfunction

    function automatic logic [31:0] pad_len();
        logic [31:0] row_bytes;
        row_bytes = hdr_width * 32'd3;
        return (hdr_depth == DEPTH_32) ? 32'd0 : ((32'd0 - row_bytes) & 32'd3);
    endfunction

    task automatic finish_row();
        col_pos  = '0;
        pad_seen = '0;
        row_pos++;
        if (row_pos >= rows_total()) begin
            parse_phase = PH_IDLE;
        end
    endtask

    // advance the parser by one accepted byte and queue the pixel it writes
    task automatic decode_byte(input logic [7:0] b, input bit first);
        logic [31:0] idx;
        logic [31:0] start;
        logic [31:0] y;
        logic [23:0] color;
        t_pixel      px;
        if (first) begin
            restart_parser();
        end
        idx = byte_pos;
        if (byte_pos != 32'hFFFF_FFFF) begin
            byte_pos++;
        end
        if (parse_phase == PH_HEADER) begin
            case (idx)
                0, 1:           hdr_sig[8*idx[0] +: 8] = b;
                10, 11, 12, 13: hdr_offset[8*(idx-10) +: 8] = b;
                18, 19, 20, 21: hdr_width[8*(idx-18) +: 8] = b;
                22, 23, 24, 25: hdr_height[8*(idx-22) +: 8] = b;
                28, 29:         hdr_depth[8*(idx-28) +: 8] = b;
                default: ;
            endcase
            if (idx == HDR_LEN - 1) begin
                if (hdr_sig == BMP_SIGNATURE
                        && (hdr_depth == DEPTH_24 || hdr_depth == DEPTH_32)
                        && hdr_width != 0 && !hdr_width[31] && hdr_height != 0) begin
                    parse_phase = PH_PIXELS;
                end else begin
                    parse_phase = PH_IDLE;
                end
            end
        end else if (parse_phase == PH_PIXELS) begin
            start = (hdr_offset < HDR_LEN) ? HDR_LEN : hdr_offset;
            if (idx >= start) begin
                if (col_pos >= hdr_width) begin
                    pad_seen++;
                    if (pad_seen >= pad_len()) begin
                        finish_row();
                    end
                end else begin
                    case (pix_byte)
                        0: color_acc = {16'h0000, b};
                        1: color_acc = {8'h00, b, color_acc[7:0]};
                        2: begin
                            color = {b, color_acc[15:0]};
                            color_acc = color;
                            y = hdr_height[31] ? row_pos : (rows_total() - 32'd1 - row_pos);
                            if (col_pos < {16'h0000, fb_w} && y < {16'h0000, fb_h}) begin
                                px.x     = col_pos[15:0];
                                px.y     = y[15:0];
                                px.color = color;
                                pending_pixels.push_back(px);
                            end
                        end
                        default: ;
                    endcase
                    pix_byte++;
                    if (pix_byte >= hdr_depth / 8) begin
                        pix_byte = 0;
                        col_pos++;
                        if (col_pos >= hdr_width && pad_len() == 0) begin
                            finish_row();
                        end
                    end
                end
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit first);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, burst_max);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        decode_byte(b, first);
        bytes_sent++;
        burst_left--;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        if (burst_left != 0) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_FB_WIDTH:  fb_w = value;
            CFG_FB_HEIGHT: fb_h = value;
            default: ;
        endcase
    endtask

    task automatic set_fb(input logic [15:0] w, input logic [15:0] h);
        wait_idle();
        write_reg(CFG_FB_WIDTH, w);
        write_reg(CFG_FB_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // cut < 0 sends the whole file; trailing bytes follow the image
    task automatic send_file(input logic [15:0] sig, input logic [31:0] offset,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] depth, input int trailing,
                             input int cut, input bit flag);
        logic [7:0]  fbytes[$];
        logic [31:0] habs;
        int unsigned row_len;
        int unsigned body;
        int          total;
        for (int i = 0; i < 54; i++) begin
            fbytes.push_back(8'($urandom));
        end
        for (int k = 0; k < 4; k++) begin
            fbytes[10+k] = offset[8*k +: 8];
            fbytes[18+k] = w[8*k +: 8];
            fbytes[22+k] = h[8*k +: 8];
        end
        fbytes[0]  = sig[7:0];
        fbytes[1]  = sig[15:8];
        fbytes[28] = depth[7:0];
        fbytes[29] = depth[15:8];
        if (offset > 54 && offset < 256) begin
            repeat (offset - 54) fbytes.push_back(8'($urandom));
        end
        habs = h[31] ? (32'd0 - h) : h;
        if ((depth == DEPTH_24 || depth == DEPTH_32) && w != 0 && w <= 64
                && habs != 0 && habs <= 64) begin
            row_len = w * (depth / 8);
            if (depth == DEPTH_24) begin
                row_len += (32'd0 - w * 32'd3) & 32'd3;
            end
            body = habs * row_len;
        end else begin
            body = 12;
        end
        repeat (body + trailing) fbytes.push_back(8'($urandom));
        total = fbytes.size();
        if (cut >= 0 && cut < total) begin
            total = cut;
        end
        for (int i = 0; i < total; i++) begin
            send_byte(fbytes[i], flag && i == 0);
        end
    endtask

    task automatic random_file();
        logic [15:0] sig;
        logic [15:0] depth;
        logic [31:0] offset;
        logic [31:0] w;
        logic [31:0] h;
        int          trailing;
        int          cut;
        int unsigned pick;
        int unsigned n;
        if ($urandom_range(0, 99) < 4) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), i == 0 && $urandom_range(0, 1) == 1);
            end
        end else begin
            sig = ($urandom_range(0, 99) < 5) ? 16'($urandom) : BMP_SIGNATURE;
            pick = $urandom_range(0, 99);
            depth = (pick < 5) ? 16'($urandom) : ((pick < 52) ? DEPTH_24 : DEPTH_32);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                w = '0;
            end else if (pick < 8) begin
                w = $urandom | 32'h8000_0000;
            end else if (pick < 11) begin
                w = $urandom_range(65, 32'h7FFF_FFFF);
            end else begin
                w = $urandom_range(1, 10);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                h = '0;
            end else if (pick < 6) begin
                h = 32'h8000_0000;
            end else if (pick < 9) begin
                h = $urandom;
            end else begin
                h = $urandom_range(1, 6);
                if ($urandom_range(0, 1) == 1) begin
                    h = 32'd0 - h;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                offset = 32'd54;
            end else if (pick < 75) begin
                offset = $urandom_range(0, 53);
            end else if (pick < 97) begin
                offset = $urandom_range(55, 90);
            end else begin
                offset = $urandom;
            end
            trailing = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 6) : 0;
            cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 120) : -1;
            send_file(sig, offset, w, h, depth, trailing, cut, $urandom_range(0, 99) >= 3);
        end
    endtask

    // receiver: shift a stall pattern, reload it now and then with a new density
    always @(posedge i_clk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pat <= 16'hFFFF;
                1:       ready_pat <= 16'($urandom);
                2:       ready_pat <= 16'($urandom | $urandom);
                default: ready_pat <= 16'($urandom & $urandom & $urandom);
            endcase
            pat_age <= $urandom_range(40, 120);
        end else begin
            ready_pat <= {ready_pat[14:0], ready_pat[15]};
            pat_age   <= pat_age - 1;
        end
        i_m_axis_tready <= ready_pat[15];
    end

    // compare a step later so that the prediction for the same edge is in place
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            #1;
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%06h",
                         $time, got.x, got.y, got.color);
                failed = 1'b1;
            end else begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, got.x);
                    failed = 1'b1;
                end
                if (got.y !== want.y) begin
                    $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, got.y);
                    failed = 1'b1;
                end
                if (got.color !== want.color) begin
                    $display("%0t: pixel_color expected %06h actual %06h",
                             $time, want.color, got.color);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_reset_without_flag();
        send_file(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, DEPTH_24, 0, -1, 1'b0);
    endtask

    task automatic test_bad_headers();
        send_file(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, 16'd16, 6, -1, 1'b1);
        send_file(16'h424D, 32'd54, 32'd2, 32'd2, DEPTH_24, 6, -1, 1'b1);
        send_file(BMP_SIGNATURE, 32'd54, 32'd1, 32'd1, DEPTH_24 + 16'd256, 4, -1, 1'b1);
    endtask

    task automatic test_offsets_and_depths();
        send_file(BMP_SIGNATURE, 32'd0, 32'd3, 32'd0 - 32'd2, DEPTH_32, 0, -1, 1'b1);
        send_file(BMP_SIGNATURE, 32'd53, 32'd1, 32'd3, DEPTH_24, 0, -1, 1'b1);
        send_file(BMP_SIGNATURE, 32'd60, 32'd4, 32'd1, DEPTH_24, 5, -1, 1'b1);
    endtask

    task automatic test_degenerate_sizes();
        send_file(BMP_SIGNATURE, 32'd54, 32'd0, 32'd2, DEPTH_24, 0, -1, 1'b1);
        send_file(BMP_SIGNATURE, 32'd54, 32'h8000_0000, 32'd2, DEPTH_32, 0, -1, 1'b1);
        send_file(BMP_SIGNATURE, 32'd54, 32'd2, 32'd0, DEPTH_24, 0, -1, 1'b1);
    endtask

    task automatic test_restart_mid_file();
        send_file(BMP_SIGNATURE, 32'd54, 32'd1, 32'h8000_0000, DEPTH_24, 0, 96, 1'b1);
        send_file(BMP_SIGNATURE, 32'd54, 32'd4, 32'd4, DEPTH_24, 0, 70, 1'b1);
        send_file(BMP_SIGNATURE, 32'd54, 32'd2, 32'd0 - 32'd1, DEPTH_32, 3, -1, 1'b1);
    endtask

    task automatic test_clipping();
        set_fb(16'd2, 16'd1);
        send_file(BMP_SIGNATURE, 32'd54, 32'd4, 32'd3, DEPTH_24, 0, -1, 1'b1);
        set_fb(16'd0, 16'd0);
        send_file(BMP_SIGNATURE, 32'd54, 32'd2, 32'd2, DEPTH_24, 0, -1, 1'b1);
        set_fb(16'hFFFF, 16'hFFFF);
        send_file(BMP_SIGNATURE, 32'd54, 32'd3, 32'd2, DEPTH_32, 0, -1, 1'b1);
    endtask

    task automatic test_random_streams();
        int unsigned first_byte_no;
        int unsigned phase_end;
        first_byte_no = bytes_sent;
        while (bytes_sent - first_byte_no < 900) begin
            case ($urandom_range(0, 3))
                0:       set_fb(16'($urandom_range(0, 10)), 16'($urandom_range(0, 8)));
                1:       set_fb(16'hFFFF, 16'hFFFF);
                2:       set_fb(16'($urandom_range(0, 16'hFFFF)),
                                16'($urandom_range(0, 16'hFFFF)));
                default: set_fb(FB_WIDTH_RST, FB_HEIGHT_RST);
            endcase
            gap_max   = $urandom_range(1, 6);
            burst_max = ($urandom_range(0, 3) == 0) ? 1_000_000 : $urandom_range(1, 30);
            phase_end = bytes_sent + $urandom_range(250, 450);
            while (bytes_sent < phase_end) begin
                random_file();
            end
        end
    endtask

    initial begin
        restart_parser();
        fb_w = FB_WIDTH_RST;
        fb_h = FB_HEIGHT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_without_flag();
        test_bad_headers();
        test_offsets_and_depths();
        test_degenerate_sizes();
        test_restart_mid_file();
        test_clipping();
        test_random_streams();
        wait_idle();
        repeat (16) @(posedge i_clk);
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== bmp_pixel_stream_decoder_core.f =====
rtl/bmpd_pkg.sv
rtl/bmpd_parser.sv
rtl/bmpd_skid.sv
rtl/bmp_pixel_stream_decoder_core.sv
bench/tb_top.sv
